/* sv/text_window_printer_unit_assert.svh */
// Assertion macros for the text window printer; the back end uses them.
`ifndef TEXT_WINDOW_PRINTER_UNIT_ASSERT_SVH
`define TEXT_WINDOW_PRINTER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TWP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TWP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/twp_pkg.sv */
// Package with the types, constants and helpers of the text window printer.
package twp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam logic [7:0]  BORDER     = 8'd2;

  localparam int unsigned JOB_N   = 5;
  localparam int unsigned J_MARK  = 0;
  localparam int unsigned J_WAIT  = 1;
  localparam int unsigned J_FILL  = 2;
  localparam int unsigned J_TILE  = 3;
  localparam int unsigned J_DELAY = 4;

  typedef enum logic [2:0] {
    REG_WIN_X      = 3'd0,
    REG_WIN_Y      = 3'd1,
    REG_WIN_W      = 3'd2,
    REG_WIN_H      = 3'd3,
    REG_CHAR_DELAY = 3'd4,
    REG_WIN_OPEN   = 3'd5,
    REG_CTRL_CODES = 3'd6,
    REG_TILE_CODES = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_TILE  = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_DELAY = 2'd2,
    CMD_WAIT  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] win_x;
    logic [7:0] win_y;
    logic [7:0] win_w;
    logic [7:0] win_h;
    logic [7:0] char_delay;
    logic       win_open;
    logic [7:0] code_end;
    logic [7:0] code_nl;
    logic [7:0] code_wait;
    logic [7:0] code_page;
    logic [7:0] fill_tile;
    logic [7:0] mark_tile;
  } cfg_t;

  typedef struct packed {
    logic [JOB_N-1:0] mask;
    logic [7:0]       tile_x;
    logic [7:0]       tile_y;
    logic [7:0]       tile;
    logic [7:0]       frames;
  } job_t;

  function automatic logic [7:0] inner_size(logic [7:0] size);
    return (size <= BORDER) ? 8'd0 : size - BORDER;
  endfunction

endpackage

/* sv/twp_front.sv */
// Front end: configuration registers, cursor and decoding of text bytes into jobs.
module twp_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [twp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [twp_pkg::CFG_DATA_W-1:0]   cfg_value_i,
  input  logic                             in_fire_i,
  input  logic [twp_pkg::BYTE_W-1:0]       text_byte_i,
  output twp_pkg::cfg_t                    cfg_o,
  output logic                             push_o,
  output twp_pkg::job_t                    job_o
);

  twp_pkg::cfg_t cfg_q, cfg_d;
  logic [7:0]    col_q, col_d, row_q, row_d;
  logic          exp_q, exp_d;

  logic [7:0] iw, ih, row_inc, row_nl, col_use;
  logic       nonempty, page_nl, wrap;

  always_comb begin
    iw       = twp_pkg::inner_size(cfg_q.win_w);
    ih       = twp_pkg::inner_size(cfg_q.win_h);
    nonempty = (iw != 8'd0) && (ih != 8'd0);
    row_inc  = row_q + 8'd1;
    page_nl  = row_inc >= ih;
    wrap     = col_q >= iw;
    row_nl   = wrap ? (page_nl ? 8'd0 : row_inc) : row_q;
    col_use  = wrap ? 8'd0 : col_q;

    cfg_d = cfg_q;
    col_d = col_q;
    row_d = row_q;
    exp_d = exp_q;
    job_o = '0;

    if (cfg_valid_i) begin
      unique case (twp_pkg::cfg_reg_e'(cfg_index_i))
        twp_pkg::REG_WIN_X:      cfg_d.win_x      = cfg_value_i[7:0];
        twp_pkg::REG_WIN_Y:      cfg_d.win_y      = cfg_value_i[7:0];
        twp_pkg::REG_WIN_W:      cfg_d.win_w      = cfg_value_i[7:0];
        twp_pkg::REG_WIN_H:      cfg_d.win_h      = cfg_value_i[7:0];
        twp_pkg::REG_CHAR_DELAY: cfg_d.char_delay = cfg_value_i[7:0];
        twp_pkg::REG_WIN_OPEN:   cfg_d.win_open   = cfg_value_i[0];
        twp_pkg::REG_CTRL_CODES: begin
          cfg_d.code_end  = cfg_value_i[7:0];
          cfg_d.code_nl   = cfg_value_i[15:8];
          cfg_d.code_wait = cfg_value_i[23:16];
          cfg_d.code_page = cfg_value_i[31:24];
        end
        twp_pkg::REG_TILE_CODES: begin
          cfg_d.fill_tile = cfg_value_i[7:0];
          cfg_d.mark_tile = cfg_value_i[15:8];
        end
        default: cfg_d = cfg_q;
      endcase
      col_d = 8'd0;
      row_d = 8'd0;
    end else if (in_fire_i) begin
      if (exp_q) begin
        exp_d = 1'b0;
        if (text_byte_i != 8'd0) begin
          job_o.mask[twp_pkg::J_DELAY] = 1'b1;
          job_o.frames                 = text_byte_i;
        end
      end else if (text_byte_i == cfg_q.code_end) begin
        exp_d = exp_q;
      end else if (text_byte_i == cfg_q.code_nl) begin
        col_d = 8'd0;
        row_d = page_nl ? 8'd0 : row_inc;
        if (page_nl) begin
          job_o.mask[twp_pkg::J_MARK] = nonempty;
          job_o.mask[twp_pkg::J_WAIT] = 1'b1;
          job_o.mask[twp_pkg::J_FILL] = nonempty;
        end
      end else if (text_byte_i == cfg_q.code_wait) begin
        exp_d = 1'b1;
      end else if (text_byte_i == cfg_q.code_page) begin
        col_d = 8'd0;
        row_d = 8'd0;
        job_o.mask[twp_pkg::J_WAIT] = 1'b1;
        job_o.mask[twp_pkg::J_FILL] = nonempty;
      end else if (cfg_q.win_open && nonempty) begin
        if (wrap && page_nl) begin
          job_o.mask[twp_pkg::J_MARK] = 1'b1;
          job_o.mask[twp_pkg::J_WAIT] = 1'b1;
          job_o.mask[twp_pkg::J_FILL] = 1'b1;
        end
        job_o.mask[twp_pkg::J_TILE]  = 1'b1;
        job_o.tile_x                 = cfg_q.win_x + 8'd1 + col_use;
        job_o.tile_y                 = cfg_q.win_y + 8'd1 + row_nl;
        job_o.tile                   = text_byte_i;
        col_d                        = col_use + 8'd1;
        row_d                        = row_nl;
        job_o.mask[twp_pkg::J_DELAY] = cfg_q.char_delay != 8'd0;
        job_o.frames                 = cfg_q.char_delay;
      end
    end
  end

  assign push_o = in_fire_i && !cfg_valid_i && (job_o.mask != '0);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      col_q <= 8'd0;
      row_q <= 8'd0;
      exp_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      col_q <= col_d;
      row_q <= row_d;
      exp_q <= exp_d;
    end
  end

endmodule

/* sv/twp_fifo.sv */
// Short job queue between the front end and the command sequencer.
module twp_fifo #(
  parameter int unsigned Depth = twp_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  twp_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output twp_pkg::job_t job_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  twp_pkg::job_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/twp_back.sv */
// Back end: expands one job into its commands, one command per cycle while the output is not stalled.
`include "text_window_printer_unit_assert.svh"

module twp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  twp_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  input  twp_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    cmd_kind_o,
  output logic [7:0]    pos_x_o,
  output logic [7:0]    pos_y_o,
  output logic [7:0]    rect_w_o,
  output logic [7:0]    rect_h_o,
  output logic [7:0]    tile_code_o,
  output logic [7:0]    frame_count_o,
  output logic          last_o
);

  twp_pkg::job_t                  job_q;
  logic [twp_pkg::JOB_N-1:0]      mask_q, mask_d, sel, mask_rest;
  logic                           adv, job_load;
  logic                           out_valid_q, out_valid_d;
  twp_pkg::cmd_kind_e             kind_q, kind_d;
  logic [7:0]                     x_q, x_d, y_q, y_d, w_q, w_d, h_q, h_d;
  logic [7:0]                     t_q, t_d, f_q, f_d;
  logic                           last_q, last_d;
  logic [7:0]                     iw, ih;

  always_comb begin
    iw        = twp_pkg::inner_size(cfg_i.win_w);
    ih        = twp_pkg::inner_size(cfg_i.win_h);
    sel       = mask_q & (~mask_q + twp_pkg::JOB_N'(1));
    mask_rest = mask_q & ~sel;
    adv       = (mask_q != '0) && (!out_valid_q || out_ready_i);
    job_load  = job_valid_i && ((mask_q == '0) || (adv && (mask_rest == '0)));
    mask_d    = job_load ? job_i.mask : (adv ? mask_rest : mask_q);

    kind_d = twp_pkg::CMD_WAIT;
    x_d    = 8'd0;
    y_d    = 8'd0;
    w_d    = 8'd0;
    h_d    = 8'd0;
    t_d    = 8'd0;
    f_d    = 8'd0;
    last_d = mask_rest == '0;
    if (sel[twp_pkg::J_MARK]) begin
      kind_d = twp_pkg::CMD_TILE;
      x_d    = cfg_i.win_x + iw;
      y_d    = cfg_i.win_y + ih;
      t_d    = cfg_i.mark_tile;
    end else if (sel[twp_pkg::J_FILL]) begin
      kind_d = twp_pkg::CMD_FILL;
      x_d    = cfg_i.win_x + 8'd1;
      y_d    = cfg_i.win_y + 8'd1;
      w_d    = iw;
      h_d    = ih;
      t_d    = cfg_i.fill_tile;
    end else if (sel[twp_pkg::J_TILE]) begin
      kind_d = twp_pkg::CMD_TILE;
      x_d    = job_q.tile_x;
      y_d    = job_q.tile_y;
      t_d    = job_q.tile;
    end else if (sel[twp_pkg::J_DELAY]) begin
      kind_d = twp_pkg::CMD_DELAY;
      f_d    = job_q.frames;
    end

    out_valid_d = adv || (out_valid_q && !out_ready_i);
  end

  assign job_pop_o = job_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_q <= job_i;
    end
    if (adv) begin
      kind_q <= kind_d;
      x_q    <= x_d;
      y_q    <= y_d;
      w_q    <= w_d;
      h_q    <= h_d;
      t_q    <= t_d;
      f_q    <= f_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_kind_o    = kind_q;
  assign pos_x_o       = x_q;
  assign pos_y_o       = y_q;
  assign rect_w_o      = w_q;
  assign rect_h_o      = h_q;
  assign tile_code_o   = t_q;
  assign frame_count_o = f_q;
  assign last_o        = last_q;

  `TWP_ASSERT(a_load_nonempty, clk_i, rst_ni, job_load |=> (mask_q != '0), "Loaded job has no commands.")
  `TWP_ASSERT(a_stall_holds, clk_i, rst_ni, (mask_q != '0) && !adv && !job_load |=> $stable(mask_q), "Pending commands changed during a stall.")
  `TWP_ASSERT(a_adv_shows, clk_i, rst_ni, adv |=> out_valid_q, "Issued command did not reach the output.")
  `TWP_ASSERT_ALWAYS(a_load_when_free, clk_i, job_load |-> ((mask_q == '0) || (adv && (mask_rest == '0))), "Job loaded over pending commands.")

endmodule

/* sv/text_window_printer_unit.sv */
// Top level of the text window printer: front end, job queue and command sequencer.
//
//  Channel | Direction | Handshake              | Payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_value_i
//  in      | in        | in_valid_i/in_ready_o   | text_byte_i
//  out     | out       | out_valid_o/out_ready_i | cmd_kind_o .. last_o
//
// The front end decodes one byte per cycle while the job queue has room and no configuration write comes in.
// The sequencer sends one command per cycle while the output is ready; a printed tile with a
// delay gives a tile command and a delay command at the output.
// Reset clears the registers, the cursor and the queue; configuration is always ready.
// A stalled output holds its command and backs up into the queue and then the input.
module text_window_printer_unit #(
  parameter int unsigned FifoDepth = twp_pkg::FIFO_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [twp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [twp_pkg::CFG_DATA_W-1:0] cfg_value_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [twp_pkg::BYTE_W-1:0]     text_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     cmd_kind_o,
  output logic [7:0]                     pos_x_o,
  output logic [7:0]                     pos_y_o,
  output logic [7:0]                     rect_w_o,
  output logic [7:0]                     rect_h_o,
  output logic [7:0]                     tile_code_o,
  output logic [7:0]                     frame_count_o,
  output logic                           last_o
);

  twp_pkg::cfg_t cfg;
  twp_pkg::job_t push_job, head_job;
  logic          push, full, head_valid, pop, in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign in_fire     = in_valid_i && !full;

  twp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_value_i (cfg_value_i),
    .in_fire_i   (in_fire),
    .text_byte_i (text_byte_i),
    .cfg_o       (cfg),
    .push_o      (push),
    .job_o       (push_job)
  );

  twp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  twp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .job_valid_i   (head_valid),
    .job_i         (head_job),
    .job_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cmd_kind_o    (cmd_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .rect_w_o      (rect_w_o),
    .rect_h_o      (rect_h_o),
    .tile_code_o   (tile_code_o),
    .frame_count_o (frame_count_o),
    .last_o        (last_o)
  );

endmodule

/* verif/twp_cmd_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts the printer's command stream and compares it with the output channel.
module twp_cmd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [twp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [twp_pkg::CFG_DATA_W-1:0] cfg_value_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [twp_pkg::BYTE_W-1:0]     text_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [1:0]                     cmd_kind_i,
  input  logic [7:0]                     pos_x_i,
  input  logic [7:0]                     pos_y_i,
  input  logic [7:0]                     rect_w_i,
  input  logic [7:0]                     rect_h_i,
  input  logic [7:0]                     tile_code_i,
  input  logic [7:0]                     frame_count_i,
  input  logic                           last_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  typedef struct packed {
    twp_pkg::cmd_kind_e kind;
    logic [7:0]         x;
    logic [7:0]         y;
    logic [7:0]         w;
    logic [7:0]         h;
    logic [7:0]         tile;
    logic [7:0]         frames;
    logic               last;
  } print_cmd_t;

  print_cmd_t    cmd_q[$];
  print_cmd_t    held_cmd;
  print_cmd_t    want;
  logic          have_held;
  twp_pkg::cfg_t regs;
  logic [7:0]    col;
  logic [7:0]    row;
  logic          want_frames;
  int            fails;

  function automatic logic [7:0] interior(logic [7:0] size);
    return (size > 8'd2) ? size - 8'd2 : 8'd0;
  endfunction

  // The newest command is held back so that it can be marked as the last one of its byte.
  task automatic emit(twp_pkg::cmd_kind_e kind, logic [7:0] x, logic [7:0] y, logic [7:0] w,
                      logic [7:0] h, logic [7:0] tile, logic [7:0] frames);
    if (have_held) cmd_q.push_back(held_cmd);
    held_cmd = '{kind: kind, x: x, y: y, w: w, h: h, tile: tile, frames: frames, last: 1'b0};
    have_held = 1'b1;
  endtask

  task automatic clear_window();
    logic [7:0] iw;
    logic [7:0] ih;
    iw = interior(regs.win_w);
    ih = interior(regs.win_h);
    emit(twp_pkg::CMD_WAIT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    if (iw != 8'd0 && ih != 8'd0) begin
      emit(twp_pkg::CMD_FILL, regs.win_x + 8'd1, regs.win_y + 8'd1, iw, ih, regs.fill_tile,
           8'd0);
    end
    col = 8'd0;
    row = 8'd0;
  endtask

  task automatic advance_line();
    logic [7:0] iw;
    logic [7:0] ih;
    iw = interior(regs.win_w);
    ih = interior(regs.win_h);
    col = 8'd0;
    row = row + 8'd1;
    if (row >= ih) begin
      if (iw != 8'd0 && ih != 8'd0) begin
        emit(twp_pkg::CMD_TILE, regs.win_x + iw, regs.win_y + ih, 8'd0, 8'd0, regs.mark_tile,
             8'd0);
      end
      clear_window();
    end
  endtask

  task automatic print_tile(logic [7:0] b);
    logic [7:0] iw;
    logic [7:0] ih;
    iw = interior(regs.win_w);
    ih = interior(regs.win_h);
    if (regs.win_open && iw != 8'd0 && ih != 8'd0) begin
      if (col >= iw) advance_line();
      emit(twp_pkg::CMD_TILE, regs.win_x + 8'd1 + col, regs.win_y + 8'd1 + row, 8'd0, 8'd0, b,
           8'd0);
      col = col + 8'd1;
      if (regs.char_delay != 8'd0) begin
        emit(twp_pkg::CMD_DELAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, regs.char_delay);
      end
    end
  endtask

  task automatic predict_byte(logic [7:0] b);
    if (want_frames) begin
      want_frames = 1'b0;
      if (b != 8'd0) emit(twp_pkg::CMD_DELAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, b);
    end else if (b == regs.code_end) begin
      // The end code prints nothing.
    end else if (b == regs.code_nl) begin
      advance_line();
    end else if (b == regs.code_wait) begin
      want_frames = 1'b1;
    end else if (b == regs.code_page) begin
      clear_window();
    end else begin
      print_tile(b);
    end
    if (have_held) begin
      held_cmd.last = 1'b1;
      cmd_q.push_back(held_cmd);
      have_held = 1'b0;
    end
  endtask

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, exp_val, got_val);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '0;
      col = 8'd0;
      row = 8'd0;
      want_frames = 1'b0;
      have_held = 1'b0;
      cmd_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (twp_pkg::cfg_reg_e'(cfg_index_i))
          twp_pkg::REG_WIN_X:      regs.win_x = cfg_value_i[7:0];
          twp_pkg::REG_WIN_Y:      regs.win_y = cfg_value_i[7:0];
          twp_pkg::REG_WIN_W:      regs.win_w = cfg_value_i[7:0];
          twp_pkg::REG_WIN_H:      regs.win_h = cfg_value_i[7:0];
          twp_pkg::REG_CHAR_DELAY: regs.char_delay = cfg_value_i[7:0];
          twp_pkg::REG_WIN_OPEN:   regs.win_open = cfg_value_i[0];
          twp_pkg::REG_CTRL_CODES: begin
            {regs.code_page, regs.code_wait, regs.code_nl, regs.code_end} = cfg_value_i;
          end
          twp_pkg::REG_TILE_CODES: {regs.mark_tile, regs.fill_tile} = cfg_value_i[15:0];
          default: ;
        endcase
        col = 8'd0;
        row = 8'd0;
      end
      if (out_valid_i && out_ready_i) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: command expected none, actual kind %0d at (%0h,%0h)", $time,
                   cmd_kind_i, pos_x_i, pos_y_i);
          fails++;
        end else begin
          want = cmd_q.pop_front();
          check_field("cmd_kind", 8'(want.kind), 8'(cmd_kind_i));
          check_field("pos_x", want.x, pos_x_i);
          check_field("pos_y", want.y, pos_y_i);
          check_field("rect_w", want.w, rect_w_i);
          check_field("rect_h", want.h, rect_h_i);
          check_field("tile_code", want.tile, tile_code_i);
          check_field("frame_count", want.frames, frame_count_i);
          check_field("last", 8'(want.last), 8'(last_i));
        end
      end
      if (in_valid_i && in_ready_i) predict_byte(text_byte_i);
      fail_count_o <= fails;
      pending_o <= cmd_q.size();
    end
  end

endmodule

/* verif/tb_text_window_printer_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the text window printer: stimulus, handshake pacing and the verdict.
module tb_text_window_printer_unit;

  localparam int SettleCycles = 12;
  localparam int PhaseBytes   = 18;
  localparam int RandomPhases = 6;
  localparam logic [7:0] OpeningText [14] = '{
    8'hFF, 8'h01, 8'h41, 8'h42, 8'h43, 8'h0A, 8'h0B,
    8'h05, 8'h0B, 8'h00, 8'h0B, 8'h0A, 8'h0C, 8'h00
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [twp_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [twp_pkg::CFG_DATA_W-1:0] cfg_value_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [twp_pkg::BYTE_W-1:0]     text_byte_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [1:0]                     cmd_kind_o;
  logic [7:0]                     pos_x_o;
  logic [7:0]                     pos_y_o;
  logic [7:0]                     rect_w_o;
  logic [7:0]                     rect_h_o;
  logic [7:0]                     tile_code_o;
  logic [7:0]                     frame_count_o;
  logic                           last_o;
  int                             fail_count;
  int                             pending;
  int                             burst_left = 0;
  int                             ready_left = 0;

  text_window_printer_unit u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_value_i,
    .in_valid_i, .in_ready_o, .text_byte_i,
    .out_valid_o, .out_ready_i, .cmd_kind_o, .pos_x_o, .pos_y_o, .rect_w_o, .rect_h_o,
    .tile_code_o, .frame_count_o, .last_o
  );

  twp_cmd_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_value_i,
    .in_valid_i, .in_ready_i(in_ready_o), .text_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cmd_kind_i(cmd_kind_o), .pos_x_i(pos_x_o),
    .pos_y_i(pos_y_o), .rect_w_i(rect_w_o), .rect_h_i(rect_h_o), .tile_code_i(tile_code_o),
    .frame_count_i(frame_count_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  // The receiver switches at random between stalls, short ready runs and long ready stretches.
  always @(posedge clk_i) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          out_ready_i <= 1'b0;
          ready_left <= $urandom_range(1, 10);
        end
        1: begin
          out_ready_i <= 1'b1;
          ready_left <= $urandom_range(1, 4);
        end
        default: begin
          out_ready_i <= 1'b1;
          ready_left <= $urandom_range(20, 60);
        end
      endcase
    end
  end

  task automatic send_text(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Unused upper bits of each write carry random data.
  task automatic write_setup(twp_pkg::cfg_t s);
    int                i;
    twp_pkg::cfg_reg_e idx;
    logic [31:0]       val;
    for (i = 0; i < 8; i++) begin
      idx = twp_pkg::cfg_reg_e'(i);
      val = $urandom;
      case (idx)
        twp_pkg::REG_WIN_X:      val[7:0] = s.win_x;
        twp_pkg::REG_WIN_Y:      val[7:0] = s.win_y;
        twp_pkg::REG_WIN_W:      val[7:0] = s.win_w;
        twp_pkg::REG_WIN_H:      val[7:0] = s.win_h;
        twp_pkg::REG_CHAR_DELAY: val[7:0] = s.char_delay;
        twp_pkg::REG_WIN_OPEN:   val[0] = s.win_open;
        twp_pkg::REG_CTRL_CODES: val = {s.code_page, s.code_wait, s.code_nl, s.code_end};
        twp_pkg::REG_TILE_CODES: val[15:0] = {s.mark_tile, s.fill_tile};
        default: ;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_value_i <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_size(int typical_max);
    return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, typical_max));
  endfunction

  function automatic twp_pkg::cfg_t random_setup();
    twp_pkg::cfg_t s;
    s.win_x = 8'($urandom);
    s.win_y = 8'($urandom);
    s.win_w = pick_size(9);
    s.win_h = pick_size(6);
    s.char_delay = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    s.win_open = ($urandom_range(0, 4) != 0);
    {s.code_page, s.code_wait, s.code_nl, s.code_end} = $urandom;
    if ($urandom_range(0, 5) == 0) s.code_page = s.code_nl;
    if ($urandom_range(0, 5) == 0) s.code_wait = s.code_end;
    {s.mark_tile, s.fill_tile} = 16'($urandom);
    return s;
  endfunction

  // Mostly ordinary text with control codes mixed in; a lone wait code now and then makes
  // the following random byte its frame count.
  task automatic send_random_text(twp_pkg::cfg_t s, int count);
    int n;
    int pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_text(8'($urandom));
      end else if (pick < 14) begin
        send_text(s.code_nl);
      end else if (pick < 16) begin
        send_text(s.code_wait);
        send_text(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
        n++;
      end else if (pick < 17) begin
        send_text(s.code_page);
      end else if (pick < 18) begin
        send_text(s.code_end);
      end else begin
        send_text(s.code_wait);
      end
      n++;
    end
  endtask

  initial begin
    int            i;
    twp_pkg::cfg_t setup;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(8'h00);
    send_text(8'h5A);
    drain();

    setup = '{win_x: 8'd10, win_y: 8'd5, win_w: 8'd6, win_h: 8'd4, char_delay: 8'd3,
              win_open: 1'b1, code_end: 8'h00, code_nl: 8'h0A, code_wait: 8'h0B,
              code_page: 8'h0C, fill_tile: 8'h20, mark_tile: 8'h7F};
    write_setup(setup);
    for (i = 0; i < 14; i++) send_text(OpeningText[i]);
    drain();

    setup = '{win_x: 8'hFF, win_y: 8'hFF, win_w: 8'hFF, win_h: 8'hFF, char_delay: 8'hFF,
              win_open: 1'b1, code_end: 8'h0A, code_nl: 8'h0A, code_wait: 8'h0B,
              code_page: 8'h0B, fill_tile: 8'h00, mark_tile: 8'hFF};
    write_setup(setup);
    send_text(8'h0A);
    send_text(8'h0B);
    send_text(8'hFF);
    send_text(8'h00);
    send_text(8'hFF);
    drain();

    setup = '{win_x: 8'd3, win_y: 8'd4, win_w: 8'd2, win_h: 8'd1, char_delay: 8'd1,
              win_open: 1'b1, code_end: 8'h01, code_nl: 8'h02, code_wait: 8'h03,
              code_page: 8'h04, fill_tile: 8'h55, mark_tile: 8'hAA};
    write_setup(setup);
    send_text(8'h41);
    send_text(8'h02);
    send_text(8'h04);
    drain();

    for (i = 0; i < RandomPhases; i++) begin
      setup = random_setup();
      write_setup(setup);
      send_random_text(setup, PhaseBytes);
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/twp_pkg.sv
sv/twp_front.sv
sv/twp_fifo.sv
sv/twp_back.sv
sv/text_window_printer_unit.sv
verif/twp_cmd_checker.sv
verif/tb_text_window_printer_unit.sv
